@@ sv/gtpv2_ie_boundary_parser_top_assert.svh @@
// Assertion macros for the element boundary parser.
`ifndef GTPV2_IE_BOUNDARY_PARSER_TOP_ASSERT_SVH
`define GTPV2_IE_BOUNDARY_PARSER_TOP_ASSERT_SVH

`ifndef SYNTH

// Implication checked every clock, quiet while in reset.
`define GTPIEBP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define GTPIEBP_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define GTPIEBP_ASSERT(lbl, clk, rst_n, prop, msg)
`define GTPIEBP_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

@@ sv/gtpiebp_pkg.sv @@
`default_nettype none

package gtpiebp_pkg;

  // default element limit per message
  localparam int unsigned MAX_IES_DEF = 256;

  // header flag test
  localparam logic [7:0] FLAG_MASK  = 8'hE8;
  localparam logic [7:0] FLAG_SHORT = 8'h40;

  // offset of the last header byte (8- and 12-byte headers)
  localparam logic [15:0] HDR_SHORT_LAST = 16'd7;
  localparam logic [15:0] HDR_LONG_LAST  = 16'd11;

  localparam logic [15:0] POS_MAX = 16'hFFFF;

  // result kinds
  localparam logic KIND_ELEMENT = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TOO_MANY = 2'd1;
  localparam logic [1:0] ST_OVERRUN  = 2'd2;

  // result queue
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [7:0]  index;
    logic [7:0]  etype;
    logic [15:0] length;
    logic [7:0]  instance_id;
    logic [15:0] offset;
    logic [8:0]  count;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

@@ sv/gtpv2_ie_boundary_parser_top.sv @@
`default_nettype none
// GTPv2 element boundary parser. A message, or a bare group of elements
// when header_mode is 0, enters one byte per request with last_byte_i on
// its final byte. In header mode the first byte's flags pick an 8-byte
// (flags & 0xE8 == 0x40) or 12-byte header, which is skipped. Then each
// element's 4-byte head (type, big-endian length, instance) is captured
// and an element record is returned as soon as the instance byte lands;
// the value bytes are counted down. The final byte produces a status
// result (ok / too many elements / overran end) with the element count
// and last_result set; if that byte also closes a head, the record comes
// first. Rate: one byte per cycle while in_ready_o is high. All parsing is
// a single registered pass from the accepted byte into a four-entry result
// queue that drains one result per cycle while out_ready_i is high. A result
// is queued as its byte is accepted and offered once those ahead are gone.
// in_ready_o is high while at least two queue slots are free; with the result
// side always ready the queue never holds more than two results, so requests
// are held off only by result back-pressure. Offsets saturate at 65535.
// header_mode is sampled at each message's first byte.
`include "gtpv2_ie_boundary_parser_top_assert.svh"

module gtpv2_ie_boundary_parser_top
  import gtpiebp_pkg::*;
#(
  parameter int unsigned MAX_IES = MAX_IES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        header_mode_i,
  // byte requests
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  // results
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             record_kind_o,
  output logic [1:0]       parse_status_o,
  output logic [7:0]       element_index_o,
  output logic [7:0]       element_type_o,
  output logic [15:0]      element_length_o,
  output logic [7:0]       element_instance_o,
  output logic [15:0]      element_offset_o,
  output logic [8:0]       element_count_o,
  output logic             last_result_o
);

  // element counter holds 0 .. MAX_IES
  localparam int unsigned ES_W = $clog2(MAX_IES + 1);
  localparam logic [ES_W-1:0] ES_MAX  = ES_W'(MAX_IES);
  localparam logic [ES_W:0]   ES_MAXX = (ES_W + 1)'(MAX_IES);

  // parse phases
  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_HDR   = 3'd1;
  localparam logic [2:0] PH_TYPE  = 3'd2;
  localparam logic [2:0] PH_LHI   = 3'd3;
  localparam logic [2:0] PH_LLO   = 3'd4;
  localparam logic [2:0] PH_INST  = 3'd5;
  localparam logic [2:0] PH_VAL   = 3'd6;
  localparam logic [2:0] PH_OVER  = 3'd7;

  // ---------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------
  logic header_mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_mode_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      header_mode_q <= header_mode_i;
    end
  end

  // ---------------------------------------------------------------
  // Parser state
  // ---------------------------------------------------------------
  logic [2:0]      phase_q, phase_d;
  logic            short_q, short_d;
  logic [15:0]     pos_q, pos_d;
  logic [15:0]     left_q, left_d;
  logic [ES_W-1:0] es_q, es_d;
  logic [7:0]      htype_q, htype_d;
  logic [15:0]     hlen_q, hlen_d;
  logic [15:0]     start_q, start_d;
  logic            ovf_q, ovf_d;

  logic            in_fire;
  logic            rec_push;
  logic            stat_push;
  logic [15:0]     left_dec;
  logic [ES_W:0]   started;
  logic [1:0]      status;
  logic            in_head;
  logic [31:0]     es_q_ext;
  logic [31:0]     es_d_ext;
  result_t         rec_res;
  result_t         stat_res;

  assign in_fire  = in_valid_i && in_ready_o;
  assign left_dec = (left_q != 16'd0) ? (left_q - 16'd1) : left_q;
  assign es_q_ext = 32'(es_q);

  always_comb begin
    phase_d   = phase_q;
    short_d   = short_q;
    pos_d     = pos_q;
    left_d    = left_q;
    es_d      = es_q;
    htype_d   = htype_q;
    hlen_d    = hlen_q;
    start_d   = start_q;
    ovf_d     = ovf_q;
    rec_push  = 1'b0;
    stat_push = 1'b0;
    status    = ST_OK;
    in_head   = 1'b0;
    started   = '0;
    es_d_ext  = '0;

    if (in_fire) begin
      unique case (phase_q) inside
        PH_START, PH_TYPE: begin
          if (phase_q == PH_START && header_mode_q) begin
            short_d = ((data_byte_i & FLAG_MASK) == FLAG_SHORT);
            phase_d = PH_HDR;
          end else if (es_q >= ES_MAX) begin
            phase_d = PH_OVER;
            ovf_d   = 1'b1;
          end else begin
            htype_d = data_byte_i;
            start_d = pos_q;
            phase_d = PH_LHI;
          end
        end
        PH_HDR: begin
          if (pos_q >= (short_q ? HDR_SHORT_LAST : HDR_LONG_LAST)) begin
            phase_d = PH_TYPE;
          end
        end
        PH_LHI: begin
          hlen_d  = {data_byte_i, 8'h00};
          phase_d = PH_LLO;
        end
        PH_LLO: begin
          hlen_d  = {hlen_q[15:8], data_byte_i};
          phase_d = PH_INST;
        end
        PH_INST: begin
          rec_push = 1'b1;
          es_d     = es_q + ES_W'(1);
          left_d   = hlen_q;
          phase_d  = (hlen_q == 16'd0) ? PH_TYPE : PH_VAL;
        end
        PH_VAL: begin
          left_d = left_dec;
          if (left_dec == 16'd0) begin
            phase_d = PH_TYPE;
          end
        end
        PH_OVER: begin
          ovf_d = 1'b1;
        end
        default: begin
          phase_d = phase_q;
        end
      endcase

      if (pos_q != POS_MAX) begin
        pos_d = pos_q + 16'd1;
      end

      if (last_byte_i) begin
        stat_push = 1'b1;
        in_head   = (phase_d == PH_LHI) || (phase_d == PH_LLO) || (phase_d == PH_INST);
        started   = {1'b0, es_d} + {{ES_W{1'b0}}, in_head};
        if (phase_d == PH_TYPE && !ovf_d) begin
          status = ST_OK;
        end else if (started >= ES_MAXX) begin
          status = ST_TOO_MANY;
        end else begin
          status = ST_OVERRUN;
        end
        es_d_ext = 32'(es_d);
        // back to a clean slate for the next message
        phase_d = PH_START;
        short_d = 1'b0;
        pos_d   = '0;
        left_d  = '0;
        es_d    = '0;
        htype_d = '0;
        hlen_d  = '0;
        start_d = '0;
        ovf_d   = 1'b0;
      end
    end
  end

  always_comb begin
    rec_res             = '0;
    rec_res.kind        = KIND_ELEMENT;
    rec_res.index       = es_q_ext[7:0];
    rec_res.etype       = htype_q;
    rec_res.length      = hlen_q;
    rec_res.instance_id = data_byte_i;
    rec_res.offset      = start_q;

    stat_res        = '0;
    stat_res.kind   = KIND_STATUS;
    stat_res.status = status;
    stat_res.count  = es_d_ext[8:0];
    stat_res.last   = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      short_q <= 1'b0;
      pos_q   <= '0;
      left_q  <= '0;
      es_q    <= '0;
      htype_q <= '0;
      hlen_q  <= '0;
      start_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      short_q <= short_d;
      pos_q   <= pos_d;
      left_q  <= left_d;
      es_q    <= es_d;
      htype_q <= htype_d;
      hlen_q  <= hlen_d;
      start_q <= start_d;
      ovf_q   <= ovf_d;
    end
  end

  // ---------------------------------------------------------------
  // Result queue: up to two writes per cycle, one read
  // ---------------------------------------------------------------
  result_t             q_mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q;
  logic [QPTR_W-1:0]   rd_ptr_q;
  logic [QCNT_W-1:0]   cnt_q;
  logic [QPTR_W-1:0]   wr_ptr_nxt;
  logic [1:0]          n_push;
  logic                pop;
  result_t             head;

  assign n_push     = {1'b0, rec_push} + {1'b0, stat_push};
  assign pop        = out_valid_o && out_ready_i;
  assign wr_ptr_nxt = wr_ptr_q + QPTR_W'(1);
  assign in_ready_o = (cnt_q <= QCNT_W'(QDEPTH - 2));
  assign out_valid_o = (cnt_q != '0);
  assign head       = q_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (rec_push) begin
      q_mem_q[wr_ptr_q] <= rec_res;
      if (stat_push) begin
        q_mem_q[wr_ptr_nxt] <= stat_res;
      end
    end else if (stat_push) begin
      q_mem_q[wr_ptr_q] <= stat_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPTR_W'(n_push);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      cnt_q <= cnt_q + QCNT_W'(n_push) - QCNT_W'(pop);
    end
  end

  assign record_kind_o      = head.kind;
  assign parse_status_o     = head.status;
  assign element_index_o    = head.index;
  assign element_type_o     = head.etype;
  assign element_length_o   = head.length;
  assign element_instance_o = head.instance_id;
  assign element_offset_o   = head.offset;
  assign element_count_o    = head.count;
  assign last_result_o      = head.last;

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  `GTPIEBP_NEVER(a_q_overflow, clk_i, rst_ni, cnt_q > QCNT_W'(QDEPTH), "result queue overfilled")
  `GTPIEBP_NEVER(a_es_limit, clk_i, rst_ni, es_q > ES_MAX, "element count beyond limit")
  `GTPIEBP_ASSERT(a_msg_clear, clk_i, rst_ni, (in_fire && last_byte_i) |=> (phase_q == PH_START && es_q == '0), "parser not cleared after final byte")
  `GTPIEBP_NEVER(a_val_empty, clk_i, rst_ni, phase_q == PH_VAL && left_q == 16'd0, "value phase with nothing left")
  `GTPIEBP_ASSERT(a_status_last, clk_i, rst_ni, (out_valid_o && record_kind_o == KIND_STATUS) |-> last_result_o, "status without last flag")

endmodule

`default_nettype wire

@@ verif/gtpv2_ie_boundary_parser_top_test.sv @@
`timescale 1ns / 100ps

module gtpv2_ie_boundary_parser_top_test;
  import gtpiebp_pkg::*;

  localparam int unsigned IE_LIMIT      = MAX_IES_DEF;
  localparam int unsigned RANDOM_BYTES  = 700;
  localparam int unsigned SETTLE_CYCLES = 4;    // idle gap before a register write
  localparam int unsigned TAIL_CYCLES   = 8;
  localparam int unsigned STALL_LIMIT   = 1000; // cycles without any handshake

  typedef logic [7:0] octet_q_t[$];

  // Walk position of the predictor, one per byte role in the message.
  typedef enum logic [2:0] {
    WAIT_FIRST, IN_HEADER, GET_TYPE, GET_LEN_HI, GET_LEN_LO, GET_INST, IN_VALUE, DISCARD
  } walk_e;

  // DUT inputs, all known from time zero
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        header_mode_i = 1'b1;
  logic        in_valid_i    = 1'b0;
  logic [7:0]  data_byte_i   = 8'h00;
  logic        last_byte_i   = 1'b0;
  logic        out_ready_i   = 1'b0;

  // DUT outputs
  logic        cfg_ready_o;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        record_kind_o;
  logic [1:0]  parse_status_o;
  logic [7:0]  element_index_o;
  logic [7:0]  element_type_o;
  logic [15:0] element_length_o;
  logic [7:0]  element_instance_o;
  logic [15:0] element_offset_o;
  logic [8:0]  element_count_o;
  logic        last_result_o;

  // Predictor state: our own view of the parser.
  logic        hdr_mode;
  walk_e       walk;
  logic        hdr_short;
  logic [15:0] pos;
  logic [15:0] val_left;
  int unsigned n_elems;
  logic [7:0]  cur_type;
  logic [15:0] cur_len;
  logic [15:0] cur_start;
  logic        extra_bytes;

  result_t     results_due[$];   // records and statuses not yet returned
  result_t     want_result;
  int unsigned n_fail = 0;
  int unsigned quiet_cycles = 0;
  bit          no_idle = 1'b0;   // both sides run flat out while set

  gtpv2_ie_boundary_parser_top #(
    .MAX_IES (IE_LIMIT)
  ) i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .header_mode_i      (header_mode_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .data_byte_i        (data_byte_i),
    .last_byte_i        (last_byte_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .record_kind_o      (record_kind_o),
    .parse_status_o     (parse_status_o),
    .element_index_o    (element_index_o),
    .element_type_o     (element_type_o),
    .element_length_o   (element_length_o),
    .element_instance_o (element_instance_o),
    .element_offset_o   (element_offset_o),
    .element_count_o    (element_count_o),
    .last_result_o      (last_result_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_walk();
    walk        = WAIT_FIRST;
    hdr_short   = 1'b0;
    pos         = '0;
    val_left    = '0;
    n_elems     = 0;
    cur_type    = '0;
    cur_len     = '0;
    cur_start   = '0;
    extra_bytes = 1'b0;
  endfunction

  // A type byte opens an element, unless the element budget is spent; past
  // that point everything is swallowed and only flagged.
  function automatic void take_type(input logic [7:0] b);
    if (n_elems >= IE_LIMIT) begin
      walk        = DISCARD;
      extra_bytes = 1'b1;
    end else begin
      cur_type  = b;
      cur_start = pos;
      walk      = GET_LEN_HI;
    end
  endfunction

  // Advance the walk by one accepted byte and queue whatever it produces.
  function automatic void walk_byte(input logic [7:0] b, input logic l);
    result_t     r;
    int unsigned started;
    logic [15:0] hdr_last;
    case (walk)
      WAIT_FIRST: begin
        if (hdr_mode) begin
          hdr_short = ((b & FLAG_MASK) == FLAG_SHORT);
          hdr_last  = hdr_short ? HDR_SHORT_LAST : HDR_LONG_LAST;
          walk      = (pos >= hdr_last) ? GET_TYPE : IN_HEADER;
        end else begin
          take_type(b);
        end
      end
      IN_HEADER: begin
        hdr_last = hdr_short ? HDR_SHORT_LAST : HDR_LONG_LAST;
        if (pos >= hdr_last) walk = GET_TYPE;
      end
      GET_TYPE: take_type(b);
      GET_LEN_HI: begin
        cur_len = {b, 8'h00};
        walk    = GET_LEN_LO;
      end
      GET_LEN_LO: begin
        cur_len[7:0] = b;
        walk         = GET_INST;
      end
      GET_INST: begin
        r             = '0;
        r.kind        = KIND_ELEMENT;
        r.status      = ST_OK;
        r.index       = n_elems[7:0];
        r.etype       = cur_type;
        r.length      = cur_len;
        r.instance_id = b;
        r.offset      = cur_start;
        results_due.push_back(r);
        n_elems++;
        val_left = cur_len;
        walk     = (cur_len == 16'd0) ? GET_TYPE : IN_VALUE;
      end
      IN_VALUE: begin
        if (val_left != 16'd0) val_left--;
        if (val_left == 16'd0) walk = GET_TYPE;
      end
      default: extra_bytes = 1'b1;
    endcase

    if (pos != POS_MAX) pos++;

    if (l) begin
      // an element whose head is under way counts as started
      started = n_elems;
      if (walk == GET_LEN_HI || walk == GET_LEN_LO || walk == GET_INST) started++;
      r        = '0;
      r.kind   = KIND_STATUS;
      if (walk == GET_TYPE && !extra_bytes) r.status = ST_OK;
      else if (started >= IE_LIMIT)         r.status = ST_TOO_MANY;
      else                                  r.status = ST_OVERRUN;
      r.count  = n_elems[8:0];
      r.last   = 1'b1;
      results_due.push_back(r);
      clear_walk();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and watchdog
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_fail++;
    end
  endfunction

  // Random back-pressure on the result side, ready low about 29 percent of the time.
  always @(posedge clk_i) begin
    out_ready_i <= no_idle ? 1'b1 : ($urandom_range(99) >= 29);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (results_due.size() == 0) begin
        $error("unexpected result: kind %0d status %0d", record_kind_o, parse_status_o);
        n_fail++;
      end else begin
        want_result = results_due.pop_front();
        check_field("record_kind", 16'(want_result.kind), 16'(record_kind_o));
        check_field("parse_status", 16'(want_result.status), 16'(parse_status_o));
        check_field("element_index", 16'(want_result.index), 16'(element_index_o));
        check_field("element_type", 16'(want_result.etype), 16'(element_type_o));
        check_field("element_length", want_result.length, element_length_o);
        check_field("element_instance", 16'(want_result.instance_id),
                    16'(element_instance_o));
        check_field("element_offset", want_result.offset, element_offset_o);
        check_field("element_count", 16'(want_result.count), 16'(element_count_o));
        check_field("last_result", 16'(want_result.last), 16'(last_result_o));
      end
    end
  end

  // A hang anywhere shows up as a long run of cycles with no handshake.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // One byte request. Valid is left high after acceptance so that a
  // back-to-back request never lowers and raises it in the same step;
  // anything that waits without sending lowers it first.
  task automatic send_byte(input logic [7:0] b, input logic l);
    while (!no_idle && $urandom_range(99) < 29) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= l;
    do @(posedge clk_i); while (!in_ready_o);
    walk_byte(b, l);
  endtask

  task automatic send_message(ref octet_q_t msg);
    foreach (msg[k]) send_byte(msg[k], k == msg.size() - 1);
  endtask

  // Hold off requests until every queued result has come back.
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (results_due.size() != 0);
  endtask

  // Register write only between messages with every result returned,
  // after a short idle gap.
  task automatic write_header_mode(input logic m);
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i   <= 1'b1;
    header_mode_i <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    hdr_mode = m;
  endtask

  // Message builders. The header length follows from the flag byte.
  function automatic void append_header(ref octet_q_t q, input logic [7:0] flags);
    int unsigned n;
    n = ((flags & FLAG_MASK) == FLAG_SHORT) ? 8 : 12;
    q.push_back(flags);
    repeat (n - 1) q.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void append_element(ref octet_q_t q, input logic [7:0] t,
                                         input logic [15:0] len, input logic [7:0] inst);
    q.push_back(t);
    q.push_back(len[15:8]);
    q.push_back(len[7:0]);
    q.push_back(inst);
    for (int unsigned k = 0; k < len; k++) q.push_back(8'($urandom_range(255)));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Header mode from reset: short header with a head closed by the last
  // byte (record before status), a bare long header, a message cut in
  // its header.
  task automatic test_header_forms();
    octet_q_t q;
    q = {};
    append_header(q, 8'h40);
    append_element(q, 8'hFF, 16'h0000, 8'hFF);
    send_message(q);
    q = {};
    append_header(q, 8'hFF);
    send_message(q);
    q = {8'h00};
    send_message(q);
  endtask

  // Bare groups: a value running past the end, a one-byte group, a group
  // stopping inside a head.
  task automatic test_bare_group();
    octet_q_t q;
    write_header_mode(1'b0);
    q = {};
    append_element(q, 8'h00, 16'h0001, 8'h00);
    append_element(q, 8'h80, 16'h0002, 8'h01);
    void'(q.pop_back());
    send_message(q);
    q = {8'hFF};
    send_message(q);
    q = {8'h5A, 8'hA5, 8'h00};
    send_message(q);
  endtask

  // Mostly well-formed messages with random content, some cut short, some
  // pure noise; random mode writes between messages, one flat-out stretch, and
  // hold-offs until everything has drained.
  task automatic test_random_traffic();
    octet_q_t    q;
    int unsigned sent;
    int unsigned msg_no;
    int unsigned pick;
    int unsigned n_el;
    int unsigned cut;
    logic [7:0]  flags;
    sent   = 0;
    msg_no = 0;
    while (sent < RANDOM_BYTES) begin
      msg_no++;
      if (msg_no % 9 == 0) write_header_mode(1'($urandom_range(1)));
      if (msg_no == 14) wait_results_drained();
      no_idle = (msg_no >= 20 && msg_no < 32);
      q    = {};
      pick = $urandom_range(99);
      if (pick < 90) begin
        if (hdr_mode) begin
          flags = 8'($urandom_range(255));
          if ($urandom_range(1)) flags = (flags & ~FLAG_MASK) | FLAG_SHORT;
          append_header(q, flags);
        end
        n_el = $urandom_range(4);
        if (!hdr_mode && n_el == 0) n_el = 1;
        repeat (n_el) begin
          append_element(q, 8'($urandom_range(255)),
                         16'(($urandom_range(9) == 0) ? $urandom_range(40)
                                                      : $urandom_range(5)),
                         8'($urandom_range(255)));
        end
        if (pick >= 70 && q.size() > 1) begin
          cut = $urandom_range(q.size() - 1, 1);
          q   = q[0:cut-1];
        end
      end else begin
        repeat ($urandom_range(8, 1)) q.push_back(8'($urandom_range(255)));
      end
      sent += q.size();
      send_message(q);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    hdr_mode = 1'b1;
    clear_walk();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_header_forms();
    test_bare_group();
    test_random_traffic();

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/gtpiebp_pkg.sv
sv/gtpv2_ie_boundary_parser_top.sv
verif/gtpv2_ie_boundary_parser_top_test.sv
